FILE: rtl/wfba_pkg.sv
// wfba_pkg: shared constants and controller/datapath link types for the
// worst-fit block allocator. No dependencies.
package wfba_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int SIZE_BITS_DEF  = 16;
  localparam int REQ_W          = 16;
  localparam int INDEX_W        = 6;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic empty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/worst_fit_block_allocator.sv
// worst_fit_block_allocator: top level joining controller and datapath.
// Depends on wfba_pkg, wfba_ctrl and wfba_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, request_size and
//   last_request. mode 0 appends a free block of that size; mode 1 asks for
//   the largest free block of at least that size (lowest index on a tie).
//   Output channel (out_valid/out_ready) returns ok, block_index and
//   batch_end, one result per input transfer, in order.
//   A load, or an allocation on an empty table, goes straight to its final
//   step; an allocation with N blocks loaded first scans all N entries. The
//   scan reads one table entry per cycle through the single read port of
//   the block memory and one comparator.
//   One item is in work at a time; the next input transfer is taken the
//   cycle after a result is written to the output register.
//   When the receiver stalls, one finished result waits in the output
//   register and the next item runs up to its final step, then holds.
//   Reset empties the table and the output register; no clearing pass.
module worst_fit_block_allocator #(
  parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [wfba_pkg::REQ_W-1:0]   request_size,
  input  logic                         last_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic [wfba_pkg::INDEX_W-1:0] block_index,
  output logic                         batch_end
);

  wfba_pkg::cmd_t cmd;
  wfba_pkg::sts_t sts;

  wfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wfba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .request_size (request_size),
    .last_request (last_request),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .ok           (ok),
    .block_index  (block_index),
    .batch_end    (batch_end),
    .cmd          (cmd),
    .sts          (sts)
  );

`ifndef ASSERT_OFF
  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result written over a stalled transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_scan_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !in_ready)
    else $error("table read issued while idle");
`endif

endmodule

FILE: rtl/wfba_ctrl.sv
// wfba_ctrl: sequencing state machine for the worst-fit block allocator.
// Depends on wfba_pkg for the command and status types.
module wfba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wfba_pkg::sts_t  sts,
  output wfba_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          state_next = (sts.in_alloc && !sts.empty) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/wfba_dp.sv
// wfba_dp: block table memory, scan comparator, best-candidate registers
// and output register of the worst-fit block allocator. Depends on wfba_pkg.
module wfba_dp #(
  parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         mode,
  input  logic [wfba_pkg::REQ_W-1:0]   request_size,
  input  logic                         last_request,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         ok,
  output logic [wfba_pkg::INDEX_W-1:0] block_index,
  output logic                         batch_end,
  input  wfba_pkg::cmd_t               cmd,
  output wfba_pkg::sts_t               sts
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  // each entry: in-use flag above the block size
  logic [SIZE_BITS:0] mem [MAX_BLOCKS];

  logic                          mode_q;
  logic [SIZE_BITS-1:0]          size_q;
  logic                          last_q;
  logic [CNT_W-1:0]              count;
  logic [IDX_W-1:0]              ptr;
  logic                          rd_vld;
  logic [IDX_W-1:0]              rd_idx;
  logic [SIZE_BITS:0]            rd_data;
  logic                          found;
  logic [IDX_W-1:0]              best_idx;
  logic [SIZE_BITS-1:0]          best_size;

  logic [SIZE_BITS+wfba_pkg::REQ_W-1:0] size_ext;
  logic                          take;
  logic                          load_ok;
  logic                          res_ok;
  logic [IDX_W-1:0]              res_idx;
  logic [wfba_pkg::INDEX_W+IDX_W-1:0] idx_ext;
  logic                          mem_we;
  logic [SIZE_BITS:0]            mem_wdata;

  assign size_ext = {{SIZE_BITS{1'b0}}, request_size};
  assign take = rd_vld && !rd_data[SIZE_BITS] && (rd_data[SIZE_BITS-1:0] >= size_q)
                && (!found || (rd_data[SIZE_BITS-1:0] > best_size));
  assign load_ok   = count < MAX_CNT;
  assign res_ok    = mode_q ? found : load_ok;
  assign res_idx   = mode_q ? best_idx : count[IDX_W-1:0];
  assign idx_ext   = {{wfba_pkg::INDEX_W{1'b0}}, res_idx};
  assign mem_we    = cmd.finish && res_ok;
  assign mem_wdata = mode_q ? {1'b1, best_size} : {1'b0, size_q};

  assign sts.in_alloc  = mode;
  assign sts.empty     = (count == '0);
  assign sts.scan_last = ((CNT_W'(ptr) + CNT_W'(1)) == count);
  assign sts.out_free  = !out_valid || out_ready;

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[res_idx] <= mem_wdata;
    end
    if (cmd.issue) begin
      rd_data <= mem[ptr];
    end
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q <= mode;
      size_q <= size_ext[SIZE_BITS-1:0];
      last_q <= last_request;
      ptr    <= '0;
    end else if (cmd.issue) begin
      ptr <= ptr + IDX_W'(1);
    end
    if (cmd.issue) begin
      rd_idx <= ptr;
    end
    if (take) begin
      best_idx  <= rd_idx;
      best_size <= rd_data[SIZE_BITS-1:0];
    end
    if (cmd.finish) begin
      ok          <= res_ok;
      block_index <= res_ok ? idx_ext[wfba_pkg::INDEX_W-1:0] : '0;
      batch_end   <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.start) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (cmd.finish && !mode_q && load_ok) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
